@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

@@ rtl/core/sotl_pkg.sv @@
// ----------------------------------------------------------------------------
// sotl_pkg
// Types, constants and float helpers for the two-level operand transform.
// ----------------------------------------------------------------------------
package sotl_pkg;

	localparam int NUM_TERMS = 7;
	localparam logic [2:0] COL_LAST = 3'd6;
	localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
	localparam logic [15:0] FP16_QNAN = 16'h7E00;

	typedef logic [31:0] fp32_t;
	typedef logic [3:0][31:0] quad_t;
	typedef logic [3:0][3:0][31:0] item_t;
	typedef logic [NUM_TERMS-1:0][15:0] terms_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_PASS
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [1:0] ia;
		logic [1:0] ib;
	} op_t;

	// Widen fp16 to fp32 exactly
	function automatic fp32_t fp16_to_fp32(input logic [15:0] h);
		logic s;
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] p;
		logic [9:0] mn;
		logic [7:0] ex;
		fp32_t r;
		s = h[15];
		e = h[14:10];
		m = h[9:0];
		p = '0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) p = 4'(i);
		end
		if (e == 5'd31) begin
			r = {s, 8'hFF, m, 13'b0};
		end else if (e == 5'd0) begin
			if (m == 10'd0) begin
				r = {s, 31'b0};
			end else begin
				mn = 10'(m << (4'd10 - p));
				ex = 8'd103 + 8'(p);
				r = {s, ex, mn, 13'b0};
			end
		end else begin
			r = {s, 8'(e) + 8'd112, m, 13'b0};
		end
		return r;
	endfunction

	// fp32 add, round to nearest even
	function automatic fp32_t fp32_add(input fp32_t a, input fp32_t b);
		logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		logic sx, sy, st, found;
		logic [7:0] ex, ey, d;
		logic [23:0] mx, my;
		logic [49:0] sh;
		logic [26:0] ax, bx, nrm;
		logic [27:0] sum;
		logic [4:0] lz;
		logic signed [9:0] exp_n;
		logic [24:0] rnd;
		fp32_t r;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:23] == 8'd0);
		b_zero = (b[30:23] == 8'd0);
		r = '0;
		if (a_nan || b_nan) begin
			r = FP32_QNAN;
		end else if (a_inf && b_inf) begin
			r = (a[31] != b[31]) ? FP32_QNAN : a;
		end else if (a_inf) begin
			r = a;
		end else if (b_inf) begin
			r = b;
		end else if (a_zero && b_zero) begin
			r = {a[31] & b[31], 31'b0};
		end else if (a_zero) begin
			r = b;
		end else if (b_zero) begin
			r = a;
		end else begin
			// order by magnitude
			if (a[30:0] >= b[30:0]) begin
				sx = a[31]; ex = a[30:23]; mx = {1'b1, a[22:0]};
				sy = b[31]; ey = b[30:23]; my = {1'b1, b[22:0]};
			end else begin
				sx = b[31]; ex = b[30:23]; mx = {1'b1, b[22:0]};
				sy = a[31]; ey = a[30:23]; my = {1'b1, a[22:0]};
			end
			d = ex - ey;
			sh = {my, 26'b0} >> d;
			bx = sh[49:23];
			st = (|sh[22:0]) || (d > 8'd49);
			bx[0] = bx[0] | st;
			ax = {mx, 3'b0};
			if (sx == sy) begin
				sum = {1'b0, ax} + {1'b0, bx};
			end else begin
				sum = {1'b0, ax} - {1'b0, bx};
			end
			if (sum == 28'd0) begin
				r = '0;
			end else begin
				exp_n = $signed({2'b0, ex});
				lz = '0;
				found = 1'b0;
				if (sum[27]) begin
					nrm = {sum[27:2], sum[1] | sum[0]};
					exp_n = exp_n + 10'sd1;
				end else begin
					for (int i = 26; i >= 0; i--) begin
						if (!found) begin
							if (sum[i]) found = 1'b1;
							else lz = lz + 5'd1;
						end
					end
					nrm = sum[26:0] << lz;
					exp_n = exp_n - $signed({5'b0, lz});
				end
				rnd = {1'b0, nrm[26:3]} +
					25'((nrm[2] && (nrm[1] || nrm[0] || nrm[3])) ? 1 : 0);
				if (rnd[24]) begin
					rnd = rnd >> 1;
					exp_n = exp_n + 10'sd1;
				end
				if (exp_n >= 10'sd255) begin
					r = {sx, 8'hFF, 23'b0};
				end else if (exp_n <= 10'sd0) begin
					r = {sx, 31'b0};
				end else begin
					r = {sx, exp_n[7:0], rnd[22:0]};
				end
			end
		end
		return r;
	endfunction

	// Narrow fp32 to fp16, round to nearest even
	function automatic logic [15:0] fp32_to_fp16(input fp32_t f);
		logic s;
		logic [7:0] e, sh;
		logic [23:0] mant, r24, rem, half;
		logic [12:0] rm;
		logic [15:0] r16, res;
		s = f[31];
		e = f[30:23];
		mant = {1'b1, f[22:0]};
		res = '0;
		if (e == 8'hFF) begin
			res = (f[22:0] != 23'd0) ? FP16_QNAN : {s, 15'h7C00};
		end else if (e == 8'd0) begin
			res = {s, 15'b0};
		end else if (e > 8'd142) begin
			res = {s, 15'h7C00};
		end else if (e >= 8'd113) begin
			r16 = 16'(mant >> 13);
			rm = mant[12:0];
			if (rm > 13'h1000 || (rm == 13'h1000 && r16[0])) r16 = r16 + 16'd1;
			res = {s, 15'b0} | ((16'(e - 8'd113) << 10) + r16);
		end else begin
			sh = 8'd126 - e;
			if (sh > 8'd25) begin
				res = {s, 15'b0};
			end else begin
				r24 = mant >> sh;
				rem = mant & ((24'd1 << sh) - 24'd1);
				half = 24'd1 << (sh - 8'd1);
				if (rem > half || (rem == half && r24[0])) r24 = r24 + 24'd1;
				res = {s, 15'b0} | 16'(r24);
			end
		end
		return res;
	endfunction

	// Operation table of the seven-term transform
	function automatic op_t term_op(input logic [2:0] t, input logic side);
		op_t op;
		op = '{kind: OP_PASS, ia: 2'd0, ib: 2'd0};
		if (!side) begin
			case (t)
				3'd0: op = '{kind: OP_ADD, ia: 2'd0, ib: 2'd3};
				3'd1: op = '{kind: OP_ADD, ia: 2'd2, ib: 2'd3};
				3'd2: op = '{kind: OP_PASS, ia: 2'd0, ib: 2'd0};
				3'd3: op = '{kind: OP_PASS, ia: 2'd3, ib: 2'd3};
				3'd4: op = '{kind: OP_ADD, ia: 2'd0, ib: 2'd1};
				3'd5: op = '{kind: OP_SUB, ia: 2'd2, ib: 2'd0};
				3'd6: op = '{kind: OP_SUB, ia: 2'd1, ib: 2'd3};
				default: op = '{kind: OP_PASS, ia: 2'd0, ib: 2'd0};
			endcase
		end else begin
			case (t)
				3'd0: op = '{kind: OP_ADD, ia: 2'd0, ib: 2'd3};
				3'd1: op = '{kind: OP_PASS, ia: 2'd0, ib: 2'd0};
				3'd2: op = '{kind: OP_SUB, ia: 2'd1, ib: 2'd3};
				3'd3: op = '{kind: OP_SUB, ia: 2'd2, ib: 2'd0};
				3'd4: op = '{kind: OP_PASS, ia: 2'd3, ib: 2'd3};
				3'd5: op = '{kind: OP_ADD, ia: 2'd0, ib: 2'd1};
				3'd6: op = '{kind: OP_ADD, ia: 2'd2, ib: 2'd3};
				default: op = '{kind: OP_PASS, ia: 2'd0, ib: 2'd0};
			endcase
		end
		return op;
	endfunction

	// Evaluate one transform term over four values
	function automatic fp32_t apply_term(input quad_t x, input op_t op);
		fp32_t r;
		case (op.kind)
			OP_ADD: r = fp32_add(x[op.ia], x[op.ib]);
			OP_SUB: r = fp32_add(x[op.ia], {~x[op.ib][31], x[op.ib][30:0]});
			OP_PASS: r = x[op.ia];
			default: r = x[op.ia];
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/sotl_front.sv @@
// ----------------------------------------------------------------------------
// sotl_front
// Accepts an item, widens its sixteen fp16 values and offers it to the queue.
// ----------------------------------------------------------------------------
module sotl_front import sotl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] group_0,
	input  logic [63:0] group_1,
	input  logic [63:0] group_2,
	input  logic [63:0] group_3,
	input  q_status_t   q_status,
	output logic        busy,
	output logic        push,
	output item_t       item
);

	logic  valid_q;
	item_t item_q;
	item_t wide;
	logic  take;

	// widen every value of the incoming item
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			wide[0][i] = fp16_to_fp32(group_0[16*i +: 16]);
			wide[1][i] = fp16_to_fp32(group_1[16*i +: 16]);
			wide[2][i] = fp16_to_fp32(group_2[16*i +: 16]);
			wide[3][i] = fp16_to_fp32(group_3[16*i +: 16]);
		end
	end

	assign busy = valid_q && q_status.full;
	assign take = start && !busy;
	assign push = valid_q && !q_status.full;
	assign item = item_q;

	// hold the item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) item_q <= wide;
	end

endmodule

@@ rtl/core/sotl_queue.sv @@
// ----------------------------------------------------------------------------
// sotl_queue
// Two-entry queue of widened items between front and back.
// ----------------------------------------------------------------------------
module sotl_queue import sotl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     wr_item,
	input  logic      pop,
	output item_t     head,
	output q_status_t status
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign status.empty = (count_q == 2'd0);
	assign status.full  = (count_q == 2'd2);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign head = mem_q[rd_ptr_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

@@ rtl/core/sotl_back.sv @@
// ----------------------------------------------------------------------------
// sotl_back
// Walks the seven columns of the head item: inner terms, outer terms, fp16.
// ----------------------------------------------------------------------------
module sotl_back import sotl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       side,
	input  item_t      head,
	input  q_status_t  q_status,
	output logic       pop,
	output logic       result_strobe,
	output logic [2:0] column_index,
	output terms_t     terms,
	output logic       last_column
);

	logic [2:0]  col_q;
	logic        valid_s1, valid_s2, strobe_q;
	logic [2:0]  col_s1, col_s2, col_out_q;
	quad_t       inner;
	quad_t       inner_s1;
	fp32_t [NUM_TERMS-1:0] outer;
	fp32_t [NUM_TERMS-1:0] outer_s2;
	terms_t      terms_q;
	logic        active;

	assign active = !q_status.empty;
	assign pop = active && (col_q == COL_LAST);

	// inner term of the current column for each outer quadrant
	always_comb begin
		for (int q = 0; q < 4; q++) begin
			inner[q] = apply_term(head[q], term_op(col_q, side));
		end
	end

	// outer terms down the registered column
	always_comb begin
		for (int p = 0; p < NUM_TERMS; p++) begin
			outer[p] = apply_term(inner_s1, term_op(3'(p), side));
		end
	end

	// step columns and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= 3'd0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (active) col_q <= (col_q == COL_LAST) ? 3'd0 : col_q + 3'd1;
			valid_s1 <= active;
			valid_s2 <= valid_s1;
			strobe_q <= valid_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		inner_s1 <= inner;
		col_s1   <= col_q;
		outer_s2 <= outer;
		col_s2   <= col_s1;
		col_out_q <= col_s2;
		for (int p = 0; p < NUM_TERMS; p++) begin
			terms_q[p] <= fp32_to_fp16(outer_s2[p]);
		end
	end

	assign result_strobe = strobe_q;
	assign column_index = col_out_q;
	assign terms = terms_q;
	assign last_column = (col_out_q == COL_LAST);

endmodule

@@ rtl/core/strassen_two_level_operand_transform.sv @@
// Items pass the front register, the queue and the back's inner, outer and fp16 registers.
// Columns leave one a cycle; the back pops an item only after all seven of its columns.
// Up to three items are held (front register plus two-entry queue) before busy rises.
// Results carry a one-cycle strobe; the receiver cannot stall them.
// Reset (arst_n low, asynchronous) empties the pipeline and clears side_select to left.
// ----------------------------------------------------------------------------
// strassen_two_level_operand_transform
// Two-level Strassen operand transform of sixteen fp16 values into 7x7 fp16.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module strassen_two_level_operand_transform import sotl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        side_select_we,
	input  logic        side_select_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] group_0,
	input  logic [63:0] group_1,
	input  logic [63:0] group_2,
	input  logic [63:0] group_3,
	output logic        result_strobe,
	output logic [2:0]  column_index,
	output logic [15:0] term_0,
	output logic [15:0] term_1,
	output logic [15:0] term_2,
	output logic [15:0] term_3,
	output logic [15:0] term_4,
	output logic [15:0] term_5,
	output logic [15:0] term_6,
	output logic        last_column
);

	logic      side_select_q;
	logic      push, pop;
	item_t     item, head;
	q_status_t q_status;
	terms_t    terms;

	// hold the side configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_select_q <= 1'b0;
		end else if (side_select_we) begin
			side_select_q <= side_select_wdata;
		end
	end

	sotl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.group_0  (group_0),
		.group_1  (group_1),
		.group_2  (group_2),
		.group_3  (group_3),
		.q_status (q_status),
		.busy     (busy),
		.push     (push),
		.item     (item)
	);

	sotl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (item),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	sotl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.side          (side_select_q),
		.head          (head),
		.q_status      (q_status),
		.pop           (pop),
		.result_strobe (result_strobe),
		.column_index  (column_index),
		.terms         (terms),
		.last_column   (last_column)
	);

	assign term_0 = terms[0];
	assign term_1 = terms[1];
	assign term_2 = terms[2];
	assign term_3 = terms[3];
	assign term_4 = terms[4];
	assign term_5 = terms[5];
	assign term_6 = terms[6];

	// columns of an item leave back to back and in order
	`ASSERT_NEXT(a_col_step, clk, arst_n, result_strobe && !last_column, result_strobe && (column_index == $past(column_index) + 3'd1))
	`ASSERT_IMPL(a_col_range, clk, arst_n, result_strobe, column_index <= COL_LAST)
	`ASSERT_IMPL(a_busy_queue, clk, arst_n, busy, q_status.full)

endmodule

@@ verif/strassen_two_level_operand_transform_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strassen_two_level_operand_transform_tb
// Drives sixteen fp16 values per transfer through the two-level operand
// transform on both sides. Each expected 7x7 fp16 result block is computed
// with integer arithmetic, each sum rounded to fp32, and checked column by column.
// ----------------------------------------------------------------------------
module strassen_two_level_operand_transform_tb;
	import sotl_pkg::*;

	localparam logic SIDE_LEFT  = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	// Value in units of 2^-24: every fp16 value and every sum here is a multiple
	typedef struct {
		logic        is_nan;
		logic        is_inf;
		logic        sgn;
		logic [63:0] mag;
	} wide_t;

	typedef struct {
		logic [2:0]  col;
		terms_t      terms;
		logic        last;
	} column_t;

	// Scoreboard: expected column results in arrival order
	class column_board;
		column_t pending[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		function automatic int msb_of(logic [63:0] v);
			int p;
			p = -1;
			for (int i = 0; i < 64; i++) begin
				if (v[i]) p = i;
			end
			return p;
		endfunction

		function automatic wide_t from_half(logic [15:0] h);
			wide_t w;
			w.sgn = h[15];
			w.is_nan = (h[14:10] == 5'd31) && (h[9:0] != 10'd0);
			w.is_inf = (h[14:10] == 5'd31) && (h[9:0] == 10'd0);
			if (h[14:10] == 5'd0) w.mag = 64'(h[9:0]);
			else w.mag = 64'({1'b1, h[9:0]}) << (h[14:10] - 5'd1);
			return w;
		endfunction

		// Round a magnitude to the given number of significant bits, ties to even
		function automatic logic [63:0] round_sig(logic [63:0] v, int nbits);
			int p, sh;
			logic [63:0] r, rem, half;
			p = msb_of(v);
			if (p < nbits) return v;
			sh = p - nbits + 1;
			r = v >> sh;
			rem = v & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && r[0])) r = r + 64'd1;
			return r << sh;
		endfunction

		// a + b (or a - b) with the sum rounded to fp32
		function automatic wide_t add32(wide_t a, wide_t b, logic negate_b);
			wide_t w;
			logic bs;
			bs = b.sgn ^ negate_b;
			w = '{is_nan: 1'b0, is_inf: 1'b0, sgn: 1'b0, mag: 64'd0};
			if (a.is_nan || b.is_nan || (a.is_inf && b.is_inf && a.sgn != bs)) begin
				w.is_nan = 1'b1;
			end else if (a.is_inf) begin
				w.is_inf = 1'b1; w.sgn = a.sgn;
			end else if (b.is_inf) begin
				w.is_inf = 1'b1; w.sgn = bs;
			end else if (a.sgn == bs) begin
				w.sgn = a.sgn;
				w.mag = round_sig(a.mag + b.mag, 24);
				if (w.mag == 64'd0) w.sgn = a.sgn & bs;
			end else if (a.mag >= b.mag) begin
				w.sgn = a.sgn;
				w.mag = round_sig(a.mag - b.mag, 24);
				if (w.mag == 64'd0) w.sgn = 1'b0;
			end else begin
				w.sgn = bs;
				w.mag = round_sig(b.mag - a.mag, 24);
			end
			return w;
		endfunction

		function automatic logic [15:0] to_half(wide_t w);
			int p;
			logic [63:0] r, bits;
			if (w.is_nan) return FP16_QNAN;
			if (w.is_inf) return {w.sgn, 15'h7C00};
			if (w.mag < 64'd2048) return {w.sgn, 15'(w.mag)};
			r = round_sig(w.mag, 11);
			p = msb_of(r);
			bits = (64'(p - 10) << 10) + (r >> (p - 10));
			if (bits >= 64'h7C00) return {w.sgn, 15'h7C00};
			return {w.sgn, 15'(bits)};
		endfunction

		// Seven Strassen operand terms of x0..x3
		function automatic void seven_terms(input wide_t x[4], input logic side,
				output wide_t t[7]);
			t[0] = add32(x[0], x[3], 1'b0);
			if (side == SIDE_LEFT) begin
				t[1] = add32(x[2], x[3], 1'b0);
				t[2] = x[0];
				t[3] = x[3];
				t[4] = add32(x[0], x[1], 1'b0);
				t[5] = add32(x[2], x[0], 1'b1);
				t[6] = add32(x[1], x[3], 1'b1);
			end else begin
				t[1] = x[0];
				t[2] = add32(x[1], x[3], 1'b1);
				t[3] = add32(x[2], x[0], 1'b1);
				t[4] = x[3];
				t[5] = add32(x[0], x[1], 1'b0);
				t[6] = add32(x[2], x[3], 1'b0);
			end
		endfunction

		// Note an accepted transfer: queue its seven column results
		function automatic void note_transfer(logic [3:0][63:0] grp, logic side);
			wide_t x[4], colv[4], t[7], rows[4][7];
			column_t c;
			for (int q = 0; q < 4; q++) begin
				for (int i = 0; i < 4; i++) x[i] = from_half(grp[q][16*i +: 16]);
				seven_terms(x, side, t);
				for (int k = 0; k < 7; k++) rows[q][k] = t[k];
			end
			for (int k = 0; k < 7; k++) begin
				for (int q = 0; q < 4; q++) colv[q] = rows[q][k];
				seven_terms(colv, side, t);
				c.col = 3'(k);
				for (int j = 0; j < 7; j++) c.terms[j] = to_half(t[j]);
				c.last = (3'(k) == COL_LAST);
				pending.push_back(c);
			end
		endfunction

		function automatic void check_result(column_t got);
			column_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, column %0d", $time, got.col);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.col != want.col) begin
				$display("%0t: column_index expected %0d actual %0d",
					$time, want.col, got.col);
				errors++;
			end
			for (int j = 0; j < 7; j++) begin
				if (got.terms[j] !== want.terms[j]) begin
					$display("%0t: column %0d term_%0d expected %h actual %h",
						$time, want.col, j, want.terms[j], got.terms[j]);
					errors++;
				end
			end
			if (got.last !== want.last) begin
				$display("%0t: last_column expected %b actual %b",
					$time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        side_select_we;
	logic        side_select_wdata;
	logic        start;
	logic        busy;
	logic [63:0] group_0, group_1, group_2, group_3;
	logic        result_strobe;
	logic [2:0]  column_index;
	logic [15:0] term_0, term_1, term_2, term_3, term_4, term_5, term_6;
	logic        last_column;

	column_board board;
	logic        side_now;
	logic        idle_on;

	strassen_two_level_operand_transform u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.side_select_we    (side_select_we),
		.side_select_wdata (side_select_wdata),
		.start             (start),
		.busy              (busy),
		.group_0           (group_0),
		.group_1           (group_1),
		.group_2           (group_2),
		.group_3           (group_3),
		.result_strobe     (result_strobe),
		.column_index      (column_index),
		.term_0            (term_0),
		.term_1            (term_1),
		.term_2            (term_2),
		.term_3            (term_3),
		.term_4            (term_4),
		.term_5            (term_5),
		.term_6            (term_6),
		.last_column       (last_column)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Note each transfer and check each result at the edge that accepts it
	always @(posedge clk) begin
		column_t got;
		if (arst_n && start && !busy)
			board.note_transfer({group_3, group_2, group_1, group_0}, side_now);
		if (arst_n && result_strobe) begin
			got.col = column_index;
			got.terms = {term_6, term_5, term_4, term_3, term_2, term_1, term_0};
			got.last = last_column;
			board.check_result(got);
		end
	end

	// Random fp16 value, biased towards moderate exponents and specials
	function automatic logic [15:0] pick_half();
		logic [15:0] h;
		case ($urandom_range(0, 9))
			0, 1, 2: h = 16'($urandom);
			3: h = {1'($urandom), 5'd31, ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd0};
			4: h = {1'($urandom), 5'd0, 10'($urandom)};
			5: h = {1'($urandom), 5'($urandom_range(27, 30)), 10'($urandom)};
			default: h = {1'($urandom), 5'($urandom_range(10, 20)), 10'($urandom)};
		endcase
		return h;
	endfunction

	function automatic logic [63:0] pick_group();
		return {pick_half(), pick_half(), pick_half(), pick_half()};
	endfunction

	// Present one item and hold it until transferred, then idle or not
	task automatic send(input logic [63:0] g0, g1, g2, g3);
		start <= 1'b1;
		group_0 <= g0;
		group_1 <= g1;
		group_2 <= g2;
		group_3 <= g3;
		do @(posedge clk); while (busy);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_same(input logic [15:0] h);
		send({4{h}}, {4{h}}, {4{h}}, {4{h}});
	endtask

	// Drain, then write the side register while the block is idle
	task automatic set_side(input logic side);
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		side_select_we <= 1'b1;
		side_select_wdata <= side;
		side_now = side;
		@(posedge clk);
		side_select_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic directed_set();
		send_same(16'h0000);
		send_same(16'h8000);
		send_same(16'h7BFF);
		send_same(16'hFBFF);
		send_same(16'h0001);
		send_same(16'h83FF);
		send_same(16'h7C00);
		send_same(16'hFFFF);
		send_same(16'h7E01);
		// infinity minus infinity inside a quadrant and across quadrants
		send({16'h0000, 16'hFC00, 16'h3C00, 16'h7C00}, {4{16'h3C00}},
			{4{16'hFC00}}, {4{16'h7C00}});
		// overflow on narrowing and near-overflow rounding
		send({4{16'h7BFF}}, {4{16'h7BFE}}, {4{16'h7A00}}, {4{16'h7BFF}});
		// cancellation to zero and tiny residues
		send({16'h3C01, 16'hBC00, 16'h3C00, 16'hBC01},
			{16'h0001, 16'h8002, 16'h0003, 16'h8001},
			{16'h8000, 16'h0000, 16'h8000, 16'h0000},
			{16'h4000, 16'hC000, 16'h3800, 16'h2E66});
		// wide exponent spread forcing rounding in the fp32 sums
		send({16'h7BFF, 16'h0001, 16'h6400, 16'h0101},
			{16'h0001, 16'h7BFF, 16'h0201, 16'h5C00},
			{16'hE400, 16'h0003, 16'h7800, 16'h83FF},
			{16'h1234, 16'hFEDC, 16'h5555, 16'hAAAA});
		send(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	task automatic random_items(input int count);
		for (int n = 0; n < count; n++)
			send(pick_group(), pick_group(), pick_group(), pick_group());
	endtask

	initial begin
		board = new();
		side_now = SIDE_LEFT;
		idle_on = 1'b1;
		clk = 1'b0;
		arst_n = 1'b0;
		side_select_we = 1'b0;
		side_select_wdata = 1'b0;
		start = 1'b0;
		group_0 = '0;
		group_1 = '0;
		group_2 = '0;
		group_3 = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// left formulas straight from reset
		directed_set();
		random_items(45);
		set_side(SIDE_RIGHT);
		directed_set();
		random_items(45);
		set_side(SIDE_LEFT);
		random_items(20);
		// final stretch at full rate
		set_side(SIDE_RIGHT);
		idle_on = 1'b0;
		random_items(25);
		start <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("strassen_two_level_operand_transform_tb: clean");
		end else begin
			$display("strassen_two_level_operand_transform_tb: errors");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#2_000_000;
		$display("strassen_two_level_operand_transform_tb: errors");
		$finish;
	end

endmodule
